@@ rtl/core/regular_grid_block_partitioner_unit_assert.svh @@
// Assertion macros shared by the block partitioner RTL.
// Included by modules that carry concurrent checks; needs a clk and rst in scope.
`ifndef REGULAR_GRID_BLOCK_PARTITIONER_UNIT_ASSERT_SVH
`define REGULAR_GRID_BLOCK_PARTITIONER_UNIT_ASSERT_SVH
`ifndef SYNTHESIS
// Property holds at every clock edge outside reset.
`define RGBP_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// Condition never holds outside reset.
`define RGBP_NEVER(lbl, cond, msg) \
  `RGBP_ASSERT(lbl, !(cond), msg)
`else
`define RGBP_ASSERT(lbl, prop, msg)
`define RGBP_NEVER(lbl, cond, msg)
`endif
`endif

@@ rtl/core/rgbp_pkg.sv @@
// Package for the block partitioner: widths, register indexes, types.
// No dependencies; used by every module of the block.
package rgbp_pkg;

  localparam int CoordW = 16;
  localparam int CntW   = 7;
  localparam int IdW    = 6;
  localparam int NDims  = 4;
  localparam int AddrW  = 3;

  localparam logic [AddrW-1:0] RegNumDims   = 3'd0;
  localparam logic [AddrW-1:0] RegDomain0   = 3'd1;
  localparam logic [AddrW-1:0] RegDomain1   = 3'd2;
  localparam logic [AddrW-1:0] RegDomain2   = 3'd3;
  localparam logic [AddrW-1:0] RegDomain3   = 3'd4;
  localparam logic [AddrW-1:0] RegNumBlocks = 3'd5;
  localparam logic [AddrW-1:0] RegNumRanks  = 3'd6;

  typedef struct packed {
    logic [2:0]                   num_dims;
    logic [NDims-1:0][CoordW-1:0] domain_size;
    logic [CntW-1:0]              num_blocks;
    logic [CntW-1:0]              num_ranks;
  } cfg_t;

  typedef struct packed {
    logic [NDims-1:0][CoordW-1:0] extent;
    logic [NDims-1:0][CoordW-1:0] start;
    logic [IdW-1:0]               local_id;
    logic [IdW-1:0]               global_id;
  } result_t;

  typedef enum logic [3:0] {
    S_IDLE, S_TEST, S_TEST_W, S_SPLIT, S_SPLIT_W, S_TAIL, S_ENUM, S_EMPTY
  } state_t;

endpackage

@@ rtl/core/rgbp_front.sv @@
// Front end: accepts rank requests into a two-entry queue.
// Depends on rgbp_pkg.
module rgbp_front (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic [rgbp_pkg::IdW-1:0] in_rank,
  output logic                     q_valid,
  input  logic                     q_pop,
  output logic [rgbp_pkg::IdW-1:0] q_rank
);

  logic [rgbp_pkg::IdW-1:0] mem [2];
  logic                     wr_ptr;
  logic                     rd_ptr;
  logic [1:0]               count;
  logic                     push;
  logic                     pop;

  assign in_ready = (count != 2'd2);
  assign q_valid  = (count != 2'd0);
  assign q_rank   = mem[rd_ptr];
  assign push     = in_valid && in_ready;
  assign pop      = q_pop && q_valid;

  // Queue storage.
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= in_rank;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop) rd_ptr <= ~rd_ptr;
      count <= count + {1'b0, push} - {1'b0, pop};
    end
  end

endmodule

@@ rtl/core/rgbp_div.sv @@
// Restoring divider, one quotient bit per cycle, 16-bit by 7-bit.
// Depends on rgbp_pkg.
module rgbp_div (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic [rgbp_pkg::CoordW-1:0] dividend,
  input  logic [rgbp_pkg::CntW-1:0]   divisor,
  output logic                        busy,
  output logic                        done,
  output logic [rgbp_pkg::CoordW-1:0] quotient,
  output logic [rgbp_pkg::CntW-1:0]   remainder
);

  logic [rgbp_pkg::CntW-1:0]   acc;
  logic [rgbp_pkg::CoordW-1:0] quo;
  logic [rgbp_pkg::CntW-1:0]   dv;
  logic [3:0]                  cnt;
  logic [rgbp_pkg::CntW:0]     shifted;
  logic [rgbp_pkg::CntW:0]     diff;
  logic                        fits;

  assign shifted   = {acc, quo[rgbp_pkg::CoordW-1]};
  assign diff      = shifted - {1'b0, dv};
  assign fits      = (shifted >= {1'b0, dv});
  assign quotient  = quo;
  assign remainder = acc;

  // Datapath: shift in one dividend bit, subtract when it fits.
  always_ff @(posedge clk) begin
    if (start) begin
      acc <= '0;
      quo <= dividend;
      dv  <= divisor;
      cnt <= '0;
    end else if (busy) begin
      acc <= fits ? diff[rgbp_pkg::CntW-1:0] : shifted[rgbp_pkg::CntW-1:0];
      quo <= {quo[rgbp_pkg::CoordW-2:0], fits};
      cnt <= cnt + 4'd1;
    end
  end

  // Control.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
      end else if (busy && cnt == 4'd15) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

endmodule

@@ rtl/core/rgbp_back.sv @@
// Back end: factors the block count, splits dimensions, then walks the lattice.
// Depends on rgbp_pkg, rgbp_div and the assertion macro header.
`include "regular_grid_block_partitioner_unit_assert.svh"
module rgbp_back (
  input  logic                     clk,
  input  logic                     rst,
  input  rgbp_pkg::cfg_t           cfg,
  input  logic                     q_valid,
  output logic                     q_pop,
  input  logic [rgbp_pkg::IdW-1:0] q_rank,
  output logic                     o_valid,
  input  logic                     o_ready,
  output rgbp_pkg::result_t        o_data,
  output logic                     o_final,
  output logic                     o_empty
);

  localparam int CW = rgbp_pkg::CoordW;
  localparam int KW = rgbp_pkg::CntW;
  localparam int IW = rgbp_pkg::IdW;
  localparam int ND = rgbp_pkg::NDims;

  rgbp_pkg::state_t state, state_next;

  logic [IW-1:0] rank;
  logic [2:0]    nd;
  logic [KW-1:0] np;
  logic [KW-1:0] total;
  logic [KW-1:0] rem;
  logic [KW-1:0] rem_q;
  logic [KW-1:0] j;
  logic [KW-1:0] p;
  logic [1:0]    best;
  logic [1:0]    best_c;
  logic [1:0]    dcnt;
  logic [IW-1:0] g;
  logic [KW-1:0] gm;
  logic [IW-1:0] lid;
  logic          found;

  logic [KW-1:0] lat  [ND];
  logic [CW-1:0] bs0  [ND];
  logic [CW-1:0] ds   [ND];
  logic [CW-1:0] tail [ND];
  logic [IW-1:0] idx  [ND];
  logic [CW-1:0] st   [ND];

  logic          div_start;
  logic [CW-1:0] div_a;
  logic [KW-1:0] div_b;
  logic          div_busy;
  logic          div_done;
  logic [CW-1:0] div_q;
  logic [KW-1:0] div_r;

  logic          slot_free;
  logic          owned;
  logic          last_g;
  logic          emit;
  logic          advance;
  logic [KW:0]   next_own;
  logic [2:0]    nd_c;
  logic [KW-1:0] nb_c;
  logic [KW-1:0] lat_mul;
  logic [CW+KW-1:0] tail_mul;
  logic [ND:0]   carry;

  rgbp_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_a),
    .divisor  (div_b),
    .busy     (div_busy),
    .done     (div_done),
    .quotient (div_q),
    .remainder(div_r)
  );

  // Clamp the configuration into range.
  always_comb begin
    nd_c = cfg.num_dims;
    if (nd_c == 3'd0) nd_c = 3'd1;
    if (nd_c > 3'(ND)) nd_c = 3'(ND);
    nb_c = cfg.num_blocks;
    if (nb_c == '0) nb_c = KW'(1);
    if (nb_c > KW'(64)) nb_c = KW'(64);
  end

  // Dimension with the largest block size, ties to the lowest index.
  always_comb begin
    best_c = 2'd0;
    for (int d = 1; d < ND; d++) begin
      if (3'(d) < nd && bs0[d] > bs0[best_c]) best_c = 2'(d);
    end
  end

  assign slot_free = !o_valid || o_ready;
  assign owned     = (gm == {1'b0, rank});
  assign last_g    = ({1'b0, g} == total - KW'(1));
  assign next_own  = {2'b0, g} + {1'b0, np};
  assign lat_mul   = KW'(lat[best] * p);
  assign tail_mul  = bs0[dcnt] * (lat[dcnt] - KW'(1));
  assign advance   = (state == rgbp_pkg::S_ENUM) && (slot_free || !owned);

  // Odometer carry chain over the lattice indexes.
  always_comb begin
    carry[0] = 1'b1;
    for (int d = 0; d < ND; d++) begin
      carry[d+1] = carry[d] && ({1'b0, idx[d]} == lat[d] - KW'(1));
    end
  end

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      rgbp_pkg::S_IDLE:    if (q_valid) begin
                             state_next = (nb_c == KW'(1)) ? rgbp_pkg::S_TAIL
                                                           : rgbp_pkg::S_TEST;
                           end
      rgbp_pkg::S_TEST:    state_next = rgbp_pkg::S_TEST_W;
      rgbp_pkg::S_TEST_W:  if (div_done) begin
                             state_next = (div_r == '0) ? rgbp_pkg::S_SPLIT
                                                        : rgbp_pkg::S_TEST;
                           end
      rgbp_pkg::S_SPLIT:   state_next = rgbp_pkg::S_SPLIT_W;
      rgbp_pkg::S_SPLIT_W: if (div_done) begin
                             state_next = (rem_q == KW'(1)) ? rgbp_pkg::S_TAIL
                                                            : rgbp_pkg::S_TEST;
                           end
      rgbp_pkg::S_TAIL:    if (dcnt == 2'(ND - 1)) state_next = rgbp_pkg::S_ENUM;
      rgbp_pkg::S_ENUM:    if (advance && last_g) begin
                             state_next = (found || owned) ? rgbp_pkg::S_IDLE
                                                           : rgbp_pkg::S_EMPTY;
                           end
      rgbp_pkg::S_EMPTY:   if (slot_free) state_next = rgbp_pkg::S_IDLE;
      default:             state_next = rgbp_pkg::S_IDLE;
    endcase
  end

  // Control outputs.
  always_comb begin
    q_pop     = 1'b0;
    div_start = 1'b0;
    div_a     = {{(CW-KW){1'b0}}, rem};
    div_b     = j;
    emit      = 1'b0;
    case (state)
      rgbp_pkg::S_IDLE:  q_pop = q_valid;
      rgbp_pkg::S_TEST:  div_start = 1'b1;
      rgbp_pkg::S_SPLIT: begin
        div_start = 1'b1;
        div_a     = bs0[best_c];
        div_b     = p;
      end
      rgbp_pkg::S_ENUM:  emit = owned && slot_free;
      rgbp_pkg::S_EMPTY: emit = slot_free;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= rgbp_pkg::S_IDLE;
    else     state <= state_next;
  end

  // Working registers.
  always_ff @(posedge clk) begin
    case (state)
      rgbp_pkg::S_IDLE: if (q_valid) begin
        rank  <= q_rank;
        nd    <= nd_c;
        np    <= (cfg.num_ranks == '0) ? KW'(1) : cfg.num_ranks;
        total <= nb_c;
        rem   <= nb_c;
        j     <= KW'(2);
        dcnt  <= '0;
        for (int d = 0; d < ND; d++) begin
          ds[d]  <= cfg.domain_size[d];
          lat[d] <= KW'(1);
          bs0[d] <= (3'(d) < nd_c) ? cfg.domain_size[d] : CW'(1);
        end
      end
      rgbp_pkg::S_TEST_W: if (div_done) begin
        if (div_r == '0) begin
          p     <= j;
          rem_q <= div_q[KW-1:0];
        end else begin
          j <= j + KW'(1);
        end
      end
      rgbp_pkg::S_SPLIT: best <= best_c;
      rgbp_pkg::S_SPLIT_W: if (div_done) begin
        bs0[best] <= div_q;
        lat[best] <= lat_mul;
        rem       <= rem_q;
        j         <= p;
      end
      rgbp_pkg::S_TAIL: begin
        tail[dcnt] <= ds[dcnt] - tail_mul[CW-1:0];
        dcnt       <= dcnt + 2'd1;
        g     <= '0;
        gm    <= '0;
        lid   <= '0;
        found <= 1'b0;
        for (int d = 0; d < ND; d++) begin
          idx[d] <= '0;
          st[d]  <= '0;
        end
      end
      rgbp_pkg::S_ENUM: if (advance) begin
        g  <= g + IW'(1);
        gm <= (gm + KW'(1) == np) ? '0 : gm + KW'(1);
        if (owned) begin
          lid   <= lid + IW'(1);
          found <= 1'b1;
        end
        for (int d = 0; d < ND; d++) begin
          if (carry[d]) begin
            if (carry[d+1]) begin
              idx[d] <= '0;
              st[d]  <= '0;
            end else begin
              idx[d] <= idx[d] + IW'(1);
              st[d]  <= st[d] + bs0[d];
            end
          end
        end
      end
      default: ;
    endcase
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      o_valid <= 1'b0;
    end else if (emit) begin
      o_valid <= 1'b1;
    end else if (o_ready) begin
      o_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      if (state == rgbp_pkg::S_EMPTY) begin
        o_data  <= '0;
        o_final <= 1'b1;
        o_empty <= 1'b1;
      end else begin
        o_data.global_id <= g;
        o_data.local_id  <= lid;
        o_final          <= (next_own >= {1'b0, total});
        o_empty          <= 1'b0;
        for (int d = 0; d < ND; d++) begin
          if (3'(d) < nd) begin
            o_data.start[d]  <= st[d];
            o_data.extent[d] <= ({1'b0, idx[d]} == lat[d] - KW'(1)) ? tail[d] : bs0[d];
          end else begin
            o_data.start[d]  <= '0;
            o_data.extent[d] <= CW'(1);
          end
        end
      end
    end
  end

  `RGBP_ASSERT(a_empty_is_final, o_valid && o_empty |-> o_final, "empty result not final")
  `RGBP_NEVER(a_div_overlap, div_start && div_busy, "divider restarted while busy")
  `RGBP_ASSERT(a_emit_free, emit |-> slot_free, "result loaded over a pending one")
  `RGBP_ASSERT(a_enum_range, state == rgbp_pkg::S_ENUM |-> {1'b0, g} < total,
               "block walk past lattice")

endmodule

@@ rtl/core/regular_grid_block_partitioner_unit.sv @@
// Regular grid block partitioner: configuration registers, front queue, back engine.
// Depends on rgbp_pkg, rgbp_front, rgbp_back.
//
// Usage: write num_dims, domain sizes, num_blocks and num_ranks through cfg_we,
// cfg_addr and cfg_wdata while the block is idle. Each beat on the s_ channel
// carries a rank id; the m_ channel returns one beat per block owned by that
// rank in row-major order, tlast on the final beat. A rank that owns nothing
// gets one beat with tuser and tlast high and zero data.
// Setup: each factoring step runs the serial divider once per trial divisor and
// once per split; a single block skips the divider, and a prime block count such
// as 61 needs the most trial divisors. The lattice walk then visits every block,
// up to 64. The back engine handles one request at a time; the two-entry input
// queue keeps accepting requests meanwhile until it is full.
// Reset clears the queue, the engine and the output register, and loads the
// register defaults (3 dims, 64x64x64x1, 1 block, 1 rank).
// When m_tready is low, the finished beat waits in the output register and
// the walk stops at the next block owned by the rank until it is taken.
module regular_grid_block_partitioner_unit (
  input  logic         clk,
  input  logic         rst,
  input  logic         cfg_we,
  input  logic [2:0]   cfg_addr,
  input  logic [15:0]  cfg_wdata,
  input  logic         s_tvalid,
  output logic         s_tready,
  input  logic [7:0]   s_tdata,   // [5:0] rank_id, [7:6] zero
  output logic         m_tvalid,
  input  logic         m_tready,
  output logic [143:0] m_tdata,   // global_id, local_id, start_0..3, extent_0..3, zero pad
  output logic         m_tlast,   // final_block
  output logic         m_tuser    // no_blocks
);

  rgbp_pkg::cfg_t            cfg;
  logic                      q_valid;
  logic                      q_pop;
  logic [rgbp_pkg::IdW-1:0]  q_rank;
  rgbp_pkg::result_t         res;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.num_dims       <= 3'd3;
      cfg.domain_size[0] <= 16'd64;
      cfg.domain_size[1] <= 16'd64;
      cfg.domain_size[2] <= 16'd64;
      cfg.domain_size[3] <= 16'd1;
      cfg.num_blocks     <= 7'd1;
      cfg.num_ranks      <= 7'd1;
    end else if (cfg_we) begin
      case (cfg_addr)
        rgbp_pkg::RegNumDims:   cfg.num_dims       <= cfg_wdata[2:0];
        rgbp_pkg::RegDomain0:   cfg.domain_size[0] <= cfg_wdata;
        rgbp_pkg::RegDomain1:   cfg.domain_size[1] <= cfg_wdata;
        rgbp_pkg::RegDomain2:   cfg.domain_size[2] <= cfg_wdata;
        rgbp_pkg::RegDomain3:   cfg.domain_size[3] <= cfg_wdata;
        rgbp_pkg::RegNumBlocks: cfg.num_blocks     <= cfg_wdata[6:0];
        rgbp_pkg::RegNumRanks:  cfg.num_ranks      <= cfg_wdata[6:0];
        default: ;
      endcase
    end
  end

  rgbp_front u_front (
    .clk     (clk),
    .rst     (rst),
    .in_valid(s_tvalid),
    .in_ready(s_tready),
    .in_rank (s_tdata[5:0]),
    .q_valid (q_valid),
    .q_pop   (q_pop),
    .q_rank  (q_rank)
  );

  rgbp_back u_back (
    .clk    (clk),
    .rst    (rst),
    .cfg    (cfg),
    .q_valid(q_valid),
    .q_pop  (q_pop),
    .q_rank (q_rank),
    .o_valid(m_tvalid),
    .o_ready(m_tready),
    .o_data (res),
    .o_final(m_tlast),
    .o_empty(m_tuser)
  );

  assign m_tdata = {4'd0, res};

endmodule

@@ verif/tb.sv @@
// Testbench for the regular grid block partitioner: directed table, then random requests.
// Depends on rgbp_pkg and regular_grid_block_partitioner_unit; self-checking, no files.
`timescale 1ns / 1ps

module tb;

  typedef struct packed {
    logic [3:0][15:0] extent;
    logic [3:0][15:0] start;
    logic [5:0]       local_id;
    logic [5:0]       global_id;
    logic             final_block;
    logic             no_blocks;
  } block_beat_t;

  // Directed stimulus row: optional register write before the request.
  typedef struct {
    bit          do_cfg;
    logic [2:0]  addr;
    logic [15:0] wdata;
    logic [5:0]  rank;
    bit          has_fixed;
    block_beat_t fixed;
  } dir_row_t;

  localparam int WatchdogLimit = 20000;

  logic         clk = 1'b0;
  logic         rst = 1'b1;
  logic         cfg_we = 1'b0;
  logic [2:0]   cfg_addr = '0;
  logic [15:0]  cfg_wdata = '0;
  logic         s_tvalid = 1'b0;
  logic         s_tready;
  logic [7:0]   s_tdata = '0;
  logic         m_tvalid;
  logic         m_tready = 1'b0;
  logic [143:0] m_tdata;
  logic         m_tlast;
  logic         m_tuser;

  // Shadow copy of the register file.
  logic [2:0]       sh_dims;
  logic [3:0][15:0] sh_domain;
  logic [6:0]       sh_blocks;
  logic [6:0]       sh_ranks;

  block_beat_t expected_beats[$];
  int          errors = 0;
  int          idle_cycles = 0;
  bit          no_stall = 1'b0;

  regular_grid_block_partitioner_unit DUT (.*);

  always #10 clk = ~clk;

  // Work out every beat one request should produce.
  task automatic predict_blocks(input logic [5:0] rank);
    int unsigned nd, rem, np, p, best, total, lid, r, idx;
    int unsigned lat[4], bsz[4], ds[4];
    block_beat_t b;
    begin
      nd = 32'(sh_dims); rem = 32'(sh_blocks); np = 32'(sh_ranks); lid = 0;
      if (nd < 1) nd = 1;
      if (nd > 4) nd = 4;
      if (rem < 1) rem = 1;
      if (rem > 64) rem = 64;
      if (np < 1) np = 1;
      for (int d = 0; d < 4; d++) begin
        ds[d] = 32'(sh_domain[d]);
        lat[d] = 1;
        bsz[d] = (d < nd) ? ds[d] : 1;
      end
      while (rem > 1) begin
        p = rem;
        for (int j = 2; j <= rem; j++)
          if (rem % j == 0) begin p = j; break; end
        best = 0;
        for (int d = 1; d < nd; d++)
          if (bsz[d] > bsz[best]) best = d;
        lat[best] *= p;
        bsz[best] /= p;
        rem /= p;
      end
      total = lat[0] * lat[1] * lat[2] * lat[3];
      if (total > 64) total = 64;
      for (int g = 0; g < total; g++) begin
        if (g % np != rank) continue;
        b = '0;
        b.global_id = g[5:0];
        b.local_id = lid[5:0];
        r = g;
        for (int d = 0; d < 4; d++) begin
          idx = r % lat[d];
          r /= lat[d];
          if (d >= nd) begin
            b.extent[d] = 16'd1;
          end else begin
            b.start[d] = 16'(idx * bsz[d]);
            b.extent[d] = 16'((idx == lat[d] - 1) ? ds[d] - bsz[d] * (lat[d] - 1) : bsz[d]);
          end
        end
        expected_beats.insert(expected_beats.size(), b);
        lid++;
      end
      if (lid == 0) begin
        b = '0;
        b.final_block = 1'b1;
        b.no_blocks = 1'b1;
        expected_beats.insert(expected_beats.size(), b);
      end else begin
        expected_beats[expected_beats.size() - 1].final_block = 1'b1;
      end
    end
  endtask

  // Register write: drive one beat on the config port, update the shadow.
  // The write enable is dropped by the next request.
  task automatic write_reg(input logic [2:0] addr, input logic [15:0] value);
    begin
      cfg_we <= 1'b1; cfg_addr <= addr; cfg_wdata <= value;
      @(negedge clk);
      case (addr)
        rgbp_pkg::RegNumDims:   sh_dims = value[2:0];
        rgbp_pkg::RegDomain0:   sh_domain[0] = value;
        rgbp_pkg::RegDomain1:   sh_domain[1] = value;
        rgbp_pkg::RegDomain2:   sh_domain[2] = value;
        rgbp_pkg::RegDomain3:   sh_domain[3] = value;
        rgbp_pkg::RegNumBlocks: sh_blocks = value[6:0];
        rgbp_pkg::RegNumRanks:  sh_ranks = value[6:0];
        default: ;
      endcase
    end
  endtask

  // Stop sending and wait for the block to drain.
  task automatic drain_results();
    begin
      s_tvalid <= 1'b0;
      while (expected_beats.size() != 0) @(negedge clk);
      repeat (40) @(negedge clk);
    end
  endtask

  // Send one rank request beat, idling at random beforehand.
  task automatic send_rank(input logic [5:0] rank);
    begin
      cfg_we <= 1'b0;
      while (!no_stall && $urandom_range(99) < 13) begin
        s_tvalid <= 1'b0;
        @(negedge clk);
      end
      s_tvalid <= 1'b1;
      s_tdata <= {2'b00, rank};
      predict_blocks(rank);
      @(posedge clk);
      while (!s_tready) @(posedge clk);
      @(negedge clk);
    end
  endtask

  // Receiver stall pattern, driven at the falling edge.
  always @(negedge clk) begin
    if (rst) m_tready <= 1'b0;
    else m_tready <= no_stall || ($urandom_range(99) >= 13);
  end

  // Compare each result beat with the oldest expectation.
  always @(posedge clk) begin
    block_beat_t got, want;
    if (!rst && m_tvalid && m_tready) begin
      got = {m_tdata[139:0], m_tlast, m_tuser};
      got.global_id = m_tdata[5:0];
      got.local_id = m_tdata[11:6];
      for (int d = 0; d < 4; d++) begin
        got.start[d] = m_tdata[12 + 16 * d +: 16];
        got.extent[d] = m_tdata[76 + 16 * d +: 16];
      end
      got.final_block = m_tlast;
      got.no_blocks = m_tuser;
      if (expected_beats.size() == 0) begin
        $display("%0t: unexpected beat %h", $time, got);
        errors++;
      end else begin
        want = expected_beats.pop_front();
        if (got !== want) begin
          $display("%0t: beat mismatch expected %h actual %h", $time, want, got);
          errors++;
        end
      end
    end
  end

  // Watchdog on cycles without any accepted beat.
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WatchdogLimit) begin
      $display("Mismatches found");
      $finish;
    end
  end

  dir_row_t dir_rows[$];

  function automatic dir_row_t mk(bit c, logic [2:0] a, logic [15:0] v, logic [5:0] rk);
    dir_row_t row;
    row.do_cfg = c; row.addr = a; row.wdata = v; row.rank = rk;
    row.has_fixed = 1'b0; row.fixed = '0;
    return row;
  endfunction

  // Append one row to the directed table.
  function automatic void add_row(dir_row_t row);
    dir_rows.insert(dir_rows.size(), row);
  endfunction

  initial begin
    dir_row_t row;
    block_beat_t fx;
    logic [2:0] ra;
    sh_dims = 3'd3; sh_domain = {16'd1, 16'd64, 16'd64, 16'd64};
    sh_blocks = 7'd1; sh_ranks = 7'd1;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // After reset: one block covering the whole 64x64x64 domain.
    row = mk(0, rgbp_pkg::RegNumDims, 0, 0);
    row.has_fixed = 1'b1;
    fx = '0; fx.final_block = 1'b1;
    fx.extent = {16'd1, 16'd64, 16'd64, 16'd64};
    row.fixed = fx;
    add_row(row);
    // Rank beyond the rank count owns nothing.
    row = mk(0, rgbp_pkg::RegNumDims, 0, 6'd63);
    row.has_fixed = 1'b1; fx = '0; fx.final_block = 1'b1; fx.no_blocks = 1'b1;
    row.fixed = fx;
    add_row(row);
    add_row(mk(1, rgbp_pkg::RegNumBlocks, 16'd64, 0));
    add_row(mk(0, rgbp_pkg::RegNumDims, 0, 0));
    add_row(mk(1, rgbp_pkg::RegNumRanks, 16'd64, 63));
    add_row(mk(0, rgbp_pkg::RegNumDims, 0, 0));
    add_row(mk(1, rgbp_pkg::RegNumBlocks, 16'd61, 60));
    add_row(mk(1, rgbp_pkg::RegNumBlocks, 16'd0, 0));
    add_row(mk(1, rgbp_pkg::RegNumBlocks, 16'd127, 5));
    add_row(mk(1, rgbp_pkg::RegNumRanks, 16'd0, 0));
    add_row(mk(1, rgbp_pkg::RegNumDims, 16'd0, 0));
    add_row(mk(1, rgbp_pkg::RegNumDims, 16'd7, 0));
    add_row(mk(1, rgbp_pkg::RegDomain0, 16'hFFFF, 0));
    add_row(mk(1, rgbp_pkg::RegDomain1, 16'd0, 0));
    add_row(mk(1, rgbp_pkg::RegDomain2, 16'd1, 0));
    add_row(mk(1, rgbp_pkg::RegDomain3, 16'd65535, 0));
    add_row(mk(1, rgbp_pkg::RegNumBlocks, 16'd60, 0));
    add_row(mk(1, rgbp_pkg::RegNumRanks, 16'd7, 6));
    add_row(mk(1, rgbp_pkg::RegNumDims, 16'd4, 42));
    add_row(mk(1, rgbp_pkg::RegNumDims, 16'd2, 1));

    foreach (dir_rows[i]) begin
      if (dir_rows[i].do_cfg) begin
        drain_results();
        write_reg(dir_rows[i].addr, dir_rows[i].wdata);
      end
      send_rank(dir_rows[i].rank);
      // Rows with a typed-in answer replace the predicted beat.
      if (dir_rows[i].has_fixed)
        expected_beats[expected_beats.size() - 1] = dir_rows[i].fixed;
    end

    // Random phases: new settings, then a burst of requests.
    for (int ph = 0; ph < 21; ph++) begin
      drain_results();
      no_stall = (ph >= 8 && ph < 11);
      for (int k = 0; k < 3; k++) begin
        ra = 3'($urandom_range(6));
        case (ra)
          rgbp_pkg::RegNumDims:   write_reg(ra, 16'($urandom_range(7)));
          rgbp_pkg::RegNumBlocks, rgbp_pkg::RegNumRanks:
            write_reg(ra, ($urandom_range(9) == 0) ? 16'($urandom_range(127))
                                                  : 16'($urandom_range(64, 1)));
          default:
            write_reg(ra, ($urandom_range(4) == 0) ? 16'($urandom)
                                                  : 16'($urandom_range(300)));
        endcase
      end
      for (int k = 0; k < 10; k++)
        send_rank(($urandom_range(3) == 0) ? 6'($urandom) : 6'($urandom_range(sh_ranks)));
    end

    drain_results();
    repeat (100) @(negedge clk);
    if (errors == 0 && expected_beats.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
